>>> design/wdnr_pkg.sv
// Shared types, codes and sizes for the weighted draw block.
`default_nettype none

package wdnr_pkg;

    // Fixed field widths of the request and response words
    localparam int IDX_BITS       = 6;
    localparam int WEIGHT_IN_BITS = 16;
    localparam int RND_BITS       = 32;
    localparam int STATUS_BITS    = 2;

    // Defaults for the top-level parameters
    localparam int POOL_DEPTH_DEF  = 64;
    localparam int WEIGHT_BITS_DEF = 16;

    // Request kinds
    localparam logic KIND_WRITE = 1'b0;
    localparam logic KIND_DRAW  = 1'b1;

    // Response status codes
    typedef enum logic [STATUS_BITS-1:0] {
        ST_WRITE = 2'd0,
        ST_DRAWN = 2'd1,
        ST_NONE  = 2'd2
    } t_status;

    // Operations of the shared add/subtract unit
    typedef enum logic {
        ALU_ADD = 1'b0,
        ALU_SUB = 1'b1
    } t_alu_op;

endpackage

`default_nettype wire

>>> design/wdnr_if.sv
// Request and response channel interfaces of the weighted draw block.
`default_nettype none

interface wdnr_in_if;
    import wdnr_pkg::*;

    logic                      valid;
    logic                      ready;
    logic                      kind;
    logic [IDX_BITS-1:0]       slot_index;
    logic                      slot_valid;
    logic                      slot_type;
    logic [WEIGHT_IN_BITS-1:0] slot_weight;
    logic                      draw_type;
    logic [RND_BITS-1:0]       random_word;

    modport source (
        output valid, kind, slot_index, slot_valid, slot_type, slot_weight,
               draw_type, random_word,
        input  ready
    );

    modport sink (
        input  valid, kind, slot_index, slot_valid, slot_type, slot_weight,
               draw_type, random_word,
        output ready
    );
endinterface

interface wdnr_out_if;
    import wdnr_pkg::*;

    logic                   valid;
    logic                   ready;
    logic [STATUS_BITS-1:0] status;
    logic [IDX_BITS-1:0]    chosen_slot;

    modport source (
        output valid, status, chosen_slot,
        input  ready
    );

    modport sink (
        input  valid, status, chosen_slot,
        output ready
    );
endinterface

`default_nettype wire

>>> design/weighted_draw_no_repeat.sv
// Top level: weighted draw with no immediate repeat, sequencer around one shared adder.
//
// Usage:
//   i_req carries one request word: kind 0 writes a table slot (valid, type and a
//   weight clamped to at least one), kind 1 draws a slot of draw_type. o_rsp
//   carries one response word per request: status and chosen_slot.
//   A write raises its response in the cycle right after acceptance.
//   A draw scans the slot table once through the entry RAM (one RAM read a
//   cycle), scans again when that total is zero (as when only the last choice
//   matched), reduces random_word modulo the total (one remainder bit per
//   cycle through the shared adder) and walks the table again, subtracting
//   weights until the roll falls inside one. If the second total is zero too,
//   the response is ST_NONE.
//   One request is in flight at a time: i_req.ready is high only when idle,
//   and the response is held on o_rsp until taken, while no new word is taken;
//   the next word can be taken in the cycle after the response is taken.
//   Reset (synchronous, active low) empties all slots and forgets the last
//   choice of both types; no clearing pass runs, the block is ready at once.
//   Slot type and weight are held in RAM; only valid bits are flip-flops.
`default_nettype none

module weighted_draw_no_repeat #(
    parameter int POOL_DEPTH  = wdnr_pkg::POOL_DEPTH_DEF,
    parameter int WEIGHT_BITS = wdnr_pkg::WEIGHT_BITS_DEF
) (
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    wdnr_in_if.sink     i_req,
    wdnr_out_if.source  o_rsp
);
    import wdnr_pkg::*;

    // Only slots reachable through the slot index field hold entries
    localparam int SLOT_DEPTH = (POOL_DEPTH < (1 << IDX_BITS)) ? POOL_DEPTH : (1 << IDX_BITS);
    localparam int IW         = $clog2(SLOT_DEPTH);
    localparam int CW         = $clog2(SLOT_DEPTH + 1);
    localparam int RAW        = $clog2(POOL_DEPTH);
    localparam int SUM_W      = WEIGHT_BITS + IW;
    localparam int AW         = SUM_W + 1;
    localparam int WEXT       = (WEIGHT_BITS > WEIGHT_IN_BITS) ? WEIGHT_BITS : WEIGHT_IN_BITS;
    localparam int BW         = $clog2(RND_BITS);
    localparam int DW         = WEIGHT_BITS + 1;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SUM,
        S_DIV,
        S_WALK,
        S_RESP
    } t_state;

    t_state                 r_state, n_state;
    logic [SLOT_DEPTH-1:0]  r_valid, n_valid;
    logic [IW-1:0]          r_lc [2];
    logic [IW-1:0]          n_lc [2];
    logic [1:0]             r_lcv, n_lcv;
    logic [CW-1:0]          r_idx, n_idx;
    logic                   r_tap_vld, n_tap_vld;
    logic [IW-1:0]          r_tap_idx, n_tap_idx;
    logic                   r_skip, n_skip;
    logic                   r_type, n_type;
    logic [SUM_W-1:0]       r_acc, n_acc;
    logic [SUM_W-1:0]       r_total, n_total;
    logic [RND_BITS-1:0]    r_rnd, n_rnd;
    logic [BW-1:0]          r_bit, n_bit;
    t_status                r_status, n_status;
    logic [IDX_BITS-1:0]    r_chosen, n_chosen;

    logic                   w_we;
    logic [RAW-1:0]         w_waddr;
    logic [DW-1:0]          w_wdata;
    logic [DW-1:0]          w_rdata;
    logic                   w_rd_type;
    logic [WEIGHT_BITS-1:0] w_rd_weight;
    logic [WEXT-1:0]        w_wext;
    logic [WEIGHT_BITS-1:0] w_wclamp;
    logic                   w_in_range;
    logic                   w_excluded;
    logic                   w_counted;
    logic                   w_issue;
    logic                   w_drained;
    logic [AW-1:0]          w_shifted;
    t_alu_op                w_op;
    logic [AW-1:0]          w_a;
    logic [AW-1:0]          w_b;
    logic [AW-1:0]          w_res;
    logic                   w_carry;

    // Saturate the written weight to the table width, store zero as one
    always_comb begin
        w_wext   = WEXT'(i_req.slot_weight);
        w_wclamp = (w_wext > WEXT'({WEIGHT_BITS{1'b1}})) ? {WEIGHT_BITS{1'b1}}
                                                         : WEIGHT_BITS'(w_wext);
        if (w_wclamp == '0) begin
            w_wclamp = WEIGHT_BITS'(1);
        end
        w_in_range = (32'(i_req.slot_index) < SLOT_DEPTH);
    end

    assign w_we    = i_req.valid && i_req.ready && (i_req.kind == KIND_WRITE) && w_in_range;
    assign w_waddr = RAW'(i_req.slot_index);
    assign w_wdata = {i_req.slot_type, w_wclamp};

    wdnr_ram #(
        .WIDTH (DW),
        .DEPTH (POOL_DEPTH)
    ) u_entry_ram (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_raddr (RAW'(r_idx[IW-1:0])),
        .o_rdata (w_rdata)
    );

    assign w_rd_type   = w_rdata[DW-1];
    assign w_rd_weight = w_rdata[WEIGHT_BITS-1:0];

    // Decide whether the slot read last cycle takes part in this scan
    always_comb begin
        w_excluded = r_skip && r_lcv[r_type] && (r_lc[r_type] == r_tap_idx);
        w_counted  = r_tap_vld && r_valid[r_tap_idx] && (w_rd_type == r_type) && !w_excluded;
        w_issue    = (r_idx != CW'(SLOT_DEPTH));
        w_drained  = !w_issue && !r_tap_vld;
        w_shifted  = {r_acc, r_rnd[RND_BITS-1]};
    end

    // Steer the shared unit: sum weights, trial subtract, or walk down the roll
    always_comb begin
        w_op = ALU_ADD;
        w_a  = AW'(r_acc);
        w_b  = AW'(w_rd_weight);
        if (r_state == S_DIV) begin
            w_op = ALU_SUB;
            w_a  = w_shifted;
            w_b  = AW'(r_total);
        end else if (r_state == S_WALK) begin
            w_op = ALU_SUB;
        end
    end

    wdnr_alu #(
        .WIDTH (AW)
    ) u_alu (
        .i_op    (w_op),
        .i_a     (w_a),
        .i_b     (w_b),
        .o_res   (w_res),
        .o_carry (w_carry)
    );

    // Sequencer
    always_comb begin
        n_state   = r_state;
        n_valid   = r_valid;
        n_lc      = r_lc;
        n_lcv     = r_lcv;
        n_idx     = r_idx;
        n_tap_vld = 1'b0;
        n_tap_idx = r_idx[IW-1:0];
        n_skip    = r_skip;
        n_type    = r_type;
        n_acc     = r_acc;
        n_total   = r_total;
        n_rnd     = r_rnd;
        n_bit     = r_bit;
        n_status  = r_status;
        n_chosen  = r_chosen;

        unique case (r_state)
            S_IDLE: begin
                if (i_req.valid) begin
                    if (i_req.kind == KIND_WRITE) begin
                        if (w_in_range) begin
                            n_valid[i_req.slot_index[IW-1:0]] = i_req.slot_valid;
                        end
                        n_status = ST_WRITE;
                        n_chosen = '0;
                        n_state  = S_RESP;
                    end else begin
                        n_type  = i_req.draw_type;
                        n_rnd   = i_req.random_word;
                        n_skip  = 1'b1;
                        n_acc   = '0;
                        n_idx   = '0;
                        n_state = S_SUM;
                    end
                end
            end
            S_SUM: begin
                // Issue one read a cycle, add the weight that comes back
                if (w_issue) begin
                    n_tap_vld = 1'b1;
                    n_idx     = r_idx + CW'(1);
                end
                if (w_counted) begin
                    n_acc = SUM_W'(w_res);
                end
                if (w_drained) begin
                    n_idx = '0;
                    if (r_acc != '0) begin
                        n_total = r_acc;
                        n_acc   = '0;
                        n_bit   = '0;
                        n_state = S_DIV;
                    end else if (r_skip) begin
                        n_skip = 1'b0;
                    end else begin
                        n_status = ST_NONE;
                        n_chosen = '0;
                        n_state  = S_RESP;
                    end
                end
            end
            S_DIV: begin
                // Bring in one dividend bit, keep the difference when it fits
                n_acc = w_carry ? SUM_W'(w_res) : SUM_W'(w_shifted);
                n_rnd = r_rnd << 1;
                n_bit = r_bit + BW'(1);
                if (r_bit == BW'(RND_BITS - 1)) begin
                    n_idx   = '0;
                    n_state = S_WALK;
                end
            end
            S_WALK: begin
                if (w_issue) begin
                    n_tap_vld = 1'b1;
                    n_idx     = r_idx + CW'(1);
                end
                if (w_counted) begin
                    if (!w_carry) begin
                        // Roll falls inside this slot's weight
                        n_lc[r_type]  = r_tap_idx;
                        n_lcv[r_type] = 1'b1;
                        n_status      = ST_DRAWN;
                        n_chosen      = IDX_BITS'(r_tap_idx);
                        n_tap_vld     = 1'b0;
                        n_state       = S_RESP;
                    end else begin
                        n_acc = SUM_W'(w_res);
                    end
                end else if (w_drained) begin
                    n_status = ST_NONE;
                    n_chosen = '0;
                    n_state  = S_RESP;
                end
            end
            S_RESP: begin
                if (o_rsp.ready) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Hold state, control and registered outputs
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_valid   <= '0;
            r_lc[0]   <= '0;
            r_lc[1]   <= '0;
            r_lcv     <= '0;
            r_idx     <= '0;
            r_tap_vld <= 1'b0;
            r_skip    <= 1'b0;
            r_bit     <= '0;
        end else begin
            r_state   <= n_state;
            r_valid   <= n_valid;
            r_lc      <= n_lc;
            r_lcv     <= n_lcv;
            r_idx     <= n_idx;
            r_tap_vld <= n_tap_vld;
            r_skip    <= n_skip;
            r_bit     <= n_bit;
        end
        r_tap_idx <= n_tap_idx;
        r_type    <= n_type;
        r_acc     <= n_acc;
        r_total   <= n_total;
        r_rnd     <= n_rnd;
        r_status  <= n_status;
        r_chosen  <= n_chosen;
    end

    assign i_req.ready       = (r_state == S_IDLE);
    assign o_rsp.valid       = (r_state == S_RESP);
    assign o_rsp.status      = r_status;
    assign o_rsp.chosen_slot = r_chosen;

`ifndef SYNTHESIS
    // Remainder stays below the divisor throughout the modulo
    a_div_rem: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DIV) |-> ((r_total != '0) && (r_acc < r_total)))
        else $error("modulo remainder not below total");

    // The walk always ends on a slot once a nonzero total was found
    a_walk_finds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !((r_state == S_WALK) && w_drained && !w_counted))
        else $error("walk ran past the table without a pick");

    // A drawn response leaves the last choice of its type recorded
    a_drawn_recorded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_rsp.valid && (r_status == ST_DRAWN)) |->
        (r_lcv[r_type] && (IDX_BITS'(r_lc[r_type]) == r_chosen)))
        else $error("drawn slot not recorded as last choice");

    // Responses other than a draw carry slot zero
    a_chosen_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_rsp.valid && (r_status != ST_DRAWN)) |-> (r_chosen == '0))
        else $error("nonzero slot on a write or empty response");

    // Reset drops any pending response
    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> (!o_rsp.valid && i_req.ready))
        else $error("block not idle after reset");
`endif

endmodule

`default_nettype wire

>>> design/wdnr_ram.sv
// Generic simple dual-port RAM with one write port and a registered read port.
`default_nettype none

module wdnr_ram #(
    parameter int WIDTH = 17,
    parameter int DEPTH = 64
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // Write one word, register the read word
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire

>>> design/wdnr_alu.sv
// Shared add/subtract unit with carry out, used for sums, modulo and the walk.
`default_nettype none

module wdnr_alu #(
    parameter int WIDTH = 23
) (
    input  wire wdnr_pkg::t_alu_op   i_op,
    input  wire logic [WIDTH-1:0]    i_a,
    input  wire logic [WIDTH-1:0]    i_b,
    output logic      [WIDTH-1:0]    o_res,
    output logic                     o_carry
);
    import wdnr_pkg::*;

    logic [WIDTH-1:0] w_b;
    logic             w_cin;

    // Invert the second operand and add one to subtract
    always_comb begin
        w_b   = (i_op == ALU_SUB) ? ~i_b : i_b;
        w_cin = (i_op == ALU_SUB);
    end

    // Carry set on subtract means a >= b
    assign {o_carry, o_res} = {1'b0, i_a} + {1'b0, w_b} + {{WIDTH{1'b0}}, w_cin};

endmodule

`default_nettype wire
